### rtl/utf8v_pkg.sv
// Shared types, codes and lead-byte decode for the UTF-8 stream validator.
package utf8v_pkg;

   localparam logic [7:0] LEAD_SIX_LO  = 8'hFC;
   localparam logic [7:0] LEAD_SIX_HI  = 8'hFD;
   localparam logic [7:0] LEAD_FIVE_LO = 8'hF8;
   localparam logic [7:0] LEAD_FOUR_LO = 8'hF0;
   localparam logic [7:0] LEAD_THREE_LO = 8'hE0;
   localparam logic [7:0] LEAD_TWO_LO  = 8'hC0;
   localparam logic [7:0] HIGH_BIT_LO  = 8'h80;

   typedef enum logic [2:0] {
      REASON_OK       = 3'd0,
      REASON_BAD_LEAD = 3'd1,
      REASON_BAD_CONT = 3'd2,
      REASON_TRUNC    = 3'd3,
      REASON_ASCII    = 3'd4
   } reason_type;

   // One byte held in the input register.
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } byte_stage_type;

   // Verdict handed from the checker to the result register.
   typedef struct packed {
      logic       load;
      logic       is_utf8;
      reason_type reason;
   } verdict_type;

   // Number of continuation bytes that follow a lead byte of 0xC0 or above.
   function automatic logic [2:0] seq_extra(input logic [7:0] b);
      logic [2:0] n;
      begin
         if (b >= LEAD_SIX_LO && b <= LEAD_SIX_HI) begin
            n = 3'd5;
         end else if (b >= LEAD_FIVE_LO) begin
            n = 3'd4;
         end else if (b >= LEAD_FOUR_LO) begin
            n = 3'd3;
         end else if (b >= LEAD_THREE_LO) begin
            n = 3'd2;
         end else begin
            n = 3'd1;
         end
         return n;
      end
   endfunction

endpackage

### rtl/utf8_stream_validator_top.sv
// Top level of the UTF-8 stream validator: input register, checker, result register.
//
//   channel  direction  ports                                      transaction
//   req      in         req_valid/req_ready, data_byte, last_byte  one text byte
//   rsp      out        rsp_valid/rsp_ready, is_utf8, reason       one verdict per stream
//
// One byte is taken every cycle unless stalled; checker state updates as the byte is consumed.
// A verdict passes the input and result registers to rsp after its last byte is accepted.
// Only a last byte can stall, and only while the result register still holds an untaken verdict.
// Synchronous reset empties both registers and returns the checker to the start of a stream.
module utf8_stream_validator_top
   import utf8v_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_utf8,
   output logic [2:0] rsp_reason
);

   byte_stage_type stage;
   verdict_type    verdict;
   logic           fire;
   logic           slot_free;

   utf8v_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .slot_free     (slot_free),
      .stage         (stage),
      .fire          (fire)
   );

   utf8v_core u_core (
      .clock   (clock),
      .reset   (reset),
      .stage   (stage),
      .fire    (fire),
      .verdict (verdict)
   );

   utf8v_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .verdict     (verdict),
      .slot_free   (slot_free),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_is_utf8 (rsp_is_utf8),
      .rsp_reason  (rsp_reason)
   );

endmodule

### rtl/utf8v_in_stage.sv
// Input register that holds one byte until the checker consumes it.
module utf8v_in_stage
   import utf8v_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [7:0]     req_data_byte,
   input  logic           req_last_byte,
   input  logic           slot_free,
   output byte_stage_type stage,
   output logic           fire
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;
   logic       last_ff;

   // A byte that is not last yields no result, so it never waits on the output side.
   assign fire      = valid_ff && (!last_ff || slot_free);
   assign req_ready = !valid_ff || fire;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data_byte;
         last_ff <= req_last_byte;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.data  = data_ff;
   assign stage.last  = last_ff;

endmodule

### rtl/utf8v_core.sv
// Sequence tracking state, first-error capture and end-of-stream verdict.
module utf8v_core
   import utf8v_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  byte_stage_type stage,
   input  logic           fire,
   output verdict_type    verdict
);

   logic [2:0] bytes_left_ff;
   logic [2:0] bytes_left_in;
   logic       all_ascii_ff;
   logic       all_ascii_in;
   reason_type first_error_ff;
   reason_type first_error_in;
   logic [2:0] nb;
   logic       na;
   reason_type ne;
   reason_type final_reason;
   logic       end_of_stream;

   always_comb begin
      nb = bytes_left_ff;
      na = all_ascii_ff;
      ne = first_error_ff;
      // Once an error is held, later bytes leave the state alone.
      if (first_error_ff == REASON_OK) begin
         if (stage.data[7]) begin
            na = 1'b0;
         end
         if (bytes_left_ff == 3'd0) begin
            if (stage.data >= HIGH_BIT_LO) begin
               if (stage.data < LEAD_TWO_LO) begin
                  ne = REASON_BAD_LEAD;
               end else begin
                  nb = seq_extra(stage.data);
               end
            end
         end else begin
            if (stage.data[7:6] != 2'b10) begin
               ne = REASON_BAD_CONT;
            end else begin
               nb = bytes_left_ff - 3'd1;
            end
         end
      end
   end

   always_comb begin
      priority if (ne != REASON_OK) begin
         final_reason = ne;
      end else if (nb != 3'd0) begin
         final_reason = REASON_TRUNC;
      end else if (na) begin
         final_reason = REASON_ASCII;
      end else begin
         final_reason = REASON_OK;
      end
   end

   assign end_of_stream = fire && stage.last;

   always_comb begin
      bytes_left_in  = bytes_left_ff;
      all_ascii_in   = all_ascii_ff;
      first_error_in = first_error_ff;
      if (end_of_stream) begin
         bytes_left_in  = 3'd0;
         all_ascii_in   = 1'b1;
         first_error_in = REASON_OK;
      end else if (fire) begin
         bytes_left_in  = nb;
         all_ascii_in   = na;
         first_error_in = ne;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff  <= 3'd0;
         all_ascii_ff   <= 1'b1;
         first_error_ff <= REASON_OK;
      end else begin
         bytes_left_ff  <= bytes_left_in;
         all_ascii_ff   <= all_ascii_in;
         first_error_ff <= first_error_in;
      end
   end

   assign verdict.load    = end_of_stream;
   assign verdict.is_utf8 = (final_reason == REASON_OK);
   assign verdict.reason  = final_reason;

   a_fire_needs_byte: assert property (@(posedge clock) disable iff (reset)
      fire |-> stage.valid)
      else $error("checker consumed an empty input register");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      end_of_stream |=> bytes_left_ff == 3'd0 && all_ascii_ff && first_error_ff == REASON_OK)
      else $error("state not cleared after the last byte of a stream");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      first_error_ff != REASON_OK && !end_of_stream |=> first_error_ff == $past(first_error_ff))
      else $error("held error changed before the end of the stream");

   a_error_freezes: assert property (@(posedge clock) disable iff (reset)
      first_error_ff != REASON_OK && !end_of_stream |=> $stable(bytes_left_ff))
      else $error("sequence count moved after an error");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      bytes_left_ff <= 3'd5)
      else $error("continuation count above the longest sequence");

endmodule

### rtl/utf8v_out_stage.sv
// Result register that holds one verdict until the consumer takes it.
module utf8v_out_stage
   import utf8v_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  verdict_type verdict,
   output logic        slot_free,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_utf8,
   output logic [2:0]  rsp_reason
);

   logic       valid_ff;
   logic       valid_in;
   logic       is_utf8_ff;
   logic [2:0] reason_ff;

   assign slot_free = !valid_ff || rsp_ready;
   assign valid_in  = verdict.load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (verdict.load) begin
         is_utf8_ff <= verdict.is_utf8;
         reason_ff  <= verdict.reason;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_is_utf8 = is_utf8_ff;
   assign rsp_reason  = reason_ff;

endmodule
